@@ hdl/gde_pkg.sv @@
// Shared types and constants of the granular delay engine.
// No dependencies; the engine and the bench use it.
package gde_pkg;

  localparam int unsigned LEN_W     = 17;  // store length, frames
  localparam int unsigned FRAC_W    = 8;   // fraction bits of a grain position
  localparam int unsigned POS_W     = LEN_W + FRAC_W;
  localparam int unsigned RATE_W    = 12;
  localparam int unsigned PH_W      = 17;  // Q1.16 phase in [0,2)
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned REM_W     = 18;
  localparam int unsigned SIZE_W    = 14;
  localparam int unsigned DIV_W     = POS_W + 1;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PH_ONE    = 131072;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_GAIN    = 3'd0,
    REG_ACTIVE_GRAINS  = 3'd1,
    REG_BUFFER_LENGTH  = 3'd2,
    REG_FREEZE         = 3'd3,
    REG_GRAIN_SPACING  = 3'd4,
    REG_GRAIN_SIZE     = 3'd5,
    REG_GRAIN_DURATION = 3'd6,
    REG_GRAIN_SPEED    = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_SCAN,
    ST_SPAWN,
    ST_SP_MUL,
    ST_SP_RED1,
    ST_SP_RED2,
    ST_SP_SZDIV,
    ST_SP_DUDIV,
    ST_SP_WRITE,
    ST_FIN,
    ST_GAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic signed [15:0] start_jitter;
    logic signed [15:0] speed_jitter;
    logic signed [15:0] size_jitter;
    logic signed [15:0] duration_jitter;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  loop_start;
    logic [LEN_W-1:0]  loop_end;
    logic [REM_W-1:0]  remaining;
    logic [RATE_W-1:0] rate;
    logic [PH_W-1:0]   phase;
    logic [STEP_W-1:0] phase_step;
    logic [PH_W-1:0]   life_phase;
    logic [STEP_W-1:0] life_step;
  } grain_rec_t;

endpackage

@@ hdl/gde_stream_if.sv @@
// Valid/ready stream channel of the granular delay engine.
// Payload type is set per instance; depends on nothing else.
interface gde_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/granular_delay_engine.sv @@
// Granular delay engine: store, grain record walk, spawn and output gain.
// Depends on gde_pkg and gde_stream_if.
//
// One input beat gives one output beat. After reset the block sweeps the sample
// store to zero, one frame a cycle, and takes no beat until that is done;
// configuration writes are taken at any time. The grain records of an item are
// read from one synchronous record memory, one slot a cycle unless the
// divider must reduce a position, through a five-stage read-modify-write
// pipeline. The shared radix-2 divider also wraps the write index into a
// shortened store and brings back each grain position that lands past it;
// an item that spawns a grain takes two passes of it for the envelope steps.
// The next beat is taken while the previous result waits in the output
// register.
module granular_delay_engine #(
  parameter int unsigned NUM_GRAINS    = 64,
  parameter int unsigned BUFFER_FRAMES = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gde_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gde_pkg::CFG_W-1:0]       cfg_data_i,
  gde_stream_if.sink                      in_i,
  gde_stream_if.source                    out_o
);

  localparam int unsigned AW     = $clog2(BUFFER_FRAMES);
  localparam int unsigned GI     = (NUM_GRAINS > 1) ? $clog2(NUM_GRAINS) : 1;
  localparam int unsigned GIW    = $clog2(NUM_GRAINS + 1);
  localparam int unsigned ACC_W  = 34 + $clog2(NUM_GRAINS);
  localparam int unsigned TOT_W  = ACC_W + 17;
  localparam int unsigned LenMax = (BUFFER_FRAMES > 131071) ? 131071 : BUFFER_FRAMES;
  localparam int unsigned DCW    = $clog2(gde_pkg::DIV_W + 1);

  localparam int unsigned LW = gde_pkg::LEN_W;
  localparam int unsigned PW = gde_pkg::POS_W;
  localparam int unsigned DW = gde_pkg::DIV_W;

  // ---------------------------------------------------------------- config
  logic [15:0] gain_q;
  logic [6:0]  grains_q;
  logic [16:0] buf_len_q;
  logic        freeze_q;
  logic [12:0] spacing_q;
  logic [12:0] size_q;
  logic [16:0] duration_q;
  logic [9:0]  speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= 16'd1024;
      grains_q   <= 7'd10;
      buf_len_q  <= 17'd48000;
      freeze_q   <= 1'b0;
      spacing_q  <= 13'd960;
      size_q     <= 13'd1440;
      duration_q <= 17'd14400;
      speed_q    <= 10'd256;
    end else if (cfg_we_i) begin
      case (gde_pkg::cfg_reg_e'(cfg_idx_i))
        gde_pkg::REG_MASTER_GAIN:    gain_q     <= cfg_data_i[15:0];
        gde_pkg::REG_ACTIVE_GRAINS:  grains_q   <= cfg_data_i[6:0];
        gde_pkg::REG_BUFFER_LENGTH:  buf_len_q  <= cfg_data_i[16:0];
        gde_pkg::REG_FREEZE:         freeze_q   <= cfg_data_i[0];
        gde_pkg::REG_GRAIN_SPACING:  spacing_q  <= cfg_data_i[12:0];
        gde_pkg::REG_GRAIN_SIZE:     size_q     <= cfg_data_i[12:0];
        gde_pkg::REG_GRAIN_DURATION: duration_q <= cfg_data_i[16:0];
        gde_pkg::REG_GRAIN_SPEED:    speed_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0]  len_c;
  logic [PW-1:0]  lenq_c;
  logic [GIW-1:0] cnt_c;

  always_comb begin
    if (buf_len_q == '0) begin
      len_c = LW'(1);
    end else if (32'(buf_len_q) > 32'(LenMax)) begin
      len_c = LW'(LenMax);
    end else begin
      len_c = buf_len_q;
    end
    lenq_c = {len_c, {gde_pkg::FRAC_W{1'b0}}};
    if (32'(grains_q) > 32'(NUM_GRAINS)) begin
      cnt_c = GIW'(NUM_GRAINS);
    end else begin
      cnt_c = GIW'(grains_q);
    end
  end

  function automatic logic [16:0] envelope(logic [16:0] p);
    logic [17:0] c;
    logic [34:0] m;
    c = 18'(gde_pkg::PH_ONE) - {1'b0, p};
    m = 35'(p) * 35'(c);
    return m[32:16];
  endfunction

  // ---------------------------------------------------------------- state
  gde_pkg::state_e state_q, state_d;

  gde_pkg::in_item_t in_q;
  logic [AW-1:0]     clr_q;
  logic [LW-1:0]     wi_q;
  logic [12:0]       cd_q;
  logic [GIW-1:0]    idx_q;
  logic              free_found_q;
  logic [GI-1:0]     free_idx_q;
  logic [NUM_GRAINS-1:0] active_q;

  // divider
  logic          div_busy_q, div_ok_q;
  logic [DCW-1:0] div_cnt_q;
  logic [DW-1:0] div_rem_q, div_quo_q, div_den_q;
  logic          div_start, div_take;
  logic [DW-1:0] div_num, div_den;

  // memories
  logic [31:0]         store_mem [BUFFER_FRAMES];
  logic [31:0]         st_rdata_q;
  logic                st_re, st_we;
  logic [AW-1:0]       st_raddr, st_waddr;
  logic [31:0]         st_wdata;

  gde_pkg::grain_rec_t grain_mem [NUM_GRAINS];
  gde_pkg::grain_rec_t gr_rdata_q, gr_wdata;
  logic                gr_re, gr_we;
  logic [GI-1:0]       gr_raddr, gr_waddr;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= store_mem[st_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gr_we) begin
      grain_mem[gr_waddr] <= gr_wdata;
    end
    if (gr_re) begin
      gr_rdata_q <= grain_mem[gr_raddr];
    end
  end

  // ---------------------------------------------------------------- pipeline regs
  logic [GI-1:0]  s1_idx_q;
  logic           s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic [16:0]    s2_ph_q, s2_lph_q;
  logic [16:0]    s3_e1_q, s3_e2_q, s4_w_q;
  logic [31:0]    s3_smp_q, s4_smp_q;
  logic signed [33:0] s5_pl_q, s5_pr_q;
  logic signed [ACC_W-1:0] acc_l_q, acc_r_q;

  // ---------------------------------------------------------------- stage 1 logic
  gde_pkg::grain_rec_t s1_rec;
  logic [PW:0]   pos_a, pos_b;
  logic [PW-1:0] pos_c;
  logic          need_div, stall, s1_go, issue, issue_act;
  logic [17:0]   ph_sum, lph_sum;
  logic          s1_drop;

  always_comb begin
    pos_a    = {1'b0, gr_rdata_q.position} + (PW + 1)'(gr_rdata_q.rate);
    pos_b    = (pos_a >= {1'b0, gr_rdata_q.loop_end, {gde_pkg::FRAC_W{1'b0}}}) ?
               {1'b0, gr_rdata_q.loop_start, {gde_pkg::FRAC_W{1'b0}}} : pos_a;
    need_div = pos_b >= {1'b0, lenq_c};
    pos_c    = need_div ? div_rem_q[PW-1:0] : pos_b[PW-1:0];
    stall    = (state_q == gde_pkg::ST_SCAN) && s1_valid_q && need_div && !div_ok_q;
    s1_go    = s1_valid_q && !stall;

    ph_sum  = {1'b0, gr_rdata_q.phase} + 18'(gr_rdata_q.phase_step);
    lph_sum = {1'b0, gr_rdata_q.life_phase} + 18'(gr_rdata_q.life_step);
    s1_drop = gr_rdata_q.remaining <= gde_pkg::REM_W'(1);

    s1_rec          = gr_rdata_q;
    s1_rec.position = pos_c;
    s1_rec.phase    = (ph_sum >= 18'(gde_pkg::PH_ONE)) ?
                      17'(ph_sum - 18'(gde_pkg::PH_ONE)) : ph_sum[16:0];
    s1_rec.life_phase = (lph_sum >= 18'(gde_pkg::PH_ONE)) ?
                        17'(lph_sum - 18'(gde_pkg::PH_ONE)) : lph_sum[16:0];
    s1_rec.remaining  = s1_drop ? '0 : gr_rdata_q.remaining - gde_pkg::REM_W'(1);

    issue     = (state_q == gde_pkg::ST_SCAN) && (idx_q < cnt_c) && !stall;
    issue_act = issue && active_q[idx_q[GI-1:0]];
  end

  // ---------------------------------------------------------------- spawn datapath
  logic [32:0] sp_pst_q;
  logic [28:0] sp_psz_q;
  logic [32:0] sp_pdu_q;
  logic [25:0] sp_prt_q;
  logic [18:0] sp_st_q;
  logic [gde_pkg::SIZE_W-1:0] sp_siz_q;
  logic [gde_pkg::REM_W-1:0]  sp_du_q;
  logic [15:0] sp_pstep_q;
  logic [15:0] f_start, f_speed, f_size, f_dur;
  logic [18:0] red1_sum;
  logic [gde_pkg::SIZE_W-1:0] siz_raw;
  logic [17:0] en_sum;
  logic [15:0] div_step;

  always_comb begin
    // factor = 32768 + jitter
    f_start  = {~in_q.start_jitter[15], in_q.start_jitter[14:0]};
    f_speed  = {~in_q.speed_jitter[15], in_q.speed_jitter[14:0]};
    f_size   = {~in_q.size_jitter[15], in_q.size_jitter[14:0]};
    f_dur    = {~in_q.duration_jitter[15], in_q.duration_jitter[14:0]};
    red1_sum = {2'b0, wi_q} + {1'b0, sp_pst_q[32:15]};
    siz_raw  = sp_psz_q[28:15];
    en_sum   = {1'b0, sp_st_q[16:0]} + 18'(sp_siz_q);
    div_step = (div_quo_q > DW'(16'hFFFF)) ? 16'hFFFF : div_quo_q[15:0];
  end

  // ---------------------------------------------------------------- output gain
  logic [35:0]               g_lo_l_q, g_lo_r_q;
  logic signed [ACC_W-4:0]   g_hi_l_q, g_hi_r_q;
  logic signed [TOT_W-1:0]   tot_l, tot_r, sh_l, sh_r;
  gde_pkg::out_item_t        res, out_q;
  logic                      out_valid_q;

  function automatic logic [15:0] sat16(logic signed [TOT_W-1:0] v);
    logic [15:0] r;
    if (v > TOT_W'(32767)) begin
      r = 16'h7FFF;
    end else if (v < -TOT_W'(32768)) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    tot_l = $signed({g_hi_l_q, 20'b0}) + $signed({{(TOT_W - 36){1'b0}}, g_lo_l_q});
    tot_r = $signed({g_hi_r_q, 20'b0}) + $signed({{(TOT_W - 36){1'b0}}, g_lo_r_q});
    sh_l  = tot_l >>> 26;
    sh_r  = tot_r >>> 26;
    res.left_out  = sat16(sh_l);
    res.right_out = sat16(sh_r);
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign in_i.ready  = (state_q == gde_pkg::ST_IDLE);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d  = state_q;
    div_start = 1'b0;
    div_take  = 1'b0;
    div_num   = DW'(gde_pkg::PH_ONE);
    div_den   = DW'(1);
    st_re     = 1'b0;
    st_raddr  = AW'(pos_c[PW-1:gde_pkg::FRAC_W]);
    st_we     = 1'b0;
    st_waddr  = clr_q;
    st_wdata  = '0;
    gr_re     = issue_act;
    gr_raddr  = idx_q[GI-1:0];
    gr_we     = 1'b0;
    gr_waddr  = s1_idx_q;
    gr_wdata  = s1_rec;

    case (state_q)
      gde_pkg::ST_CLEAR: begin
        st_we = 1'b1;
        if (32'(clr_q) == 32'(BUFFER_FRAMES - 1)) begin
          state_d = gde_pkg::ST_IDLE;
        end
      end
      gde_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = gde_pkg::ST_WRAP;
        end
      end
      gde_pkg::ST_WRAP: begin
        div_num = DW'(wi_q);
        div_den = DW'(len_c);
        if (wi_q < len_c) begin
          state_d = gde_pkg::ST_SCAN;
        end else if (div_ok_q) begin
          div_take = 1'b1;
          state_d  = gde_pkg::ST_SCAN;
        end else if (!div_busy_q) begin
          div_start = 1'b1;
        end
      end
      gde_pkg::ST_SCAN: begin
        div_num = pos_b;
        div_den = DW'(lenq_c);
        if (s1_valid_q && need_div && !div_ok_q && !div_busy_q) begin
          div_start = 1'b1;
        end
        if (s1_go) begin
          div_take = need_div;
          gr_we    = 1'b1;
          st_re    = 1'b1;
        end
        if ((idx_q == cnt_c) && !s1_valid_q && !s2_valid_q && !s3_valid_q &&
            !s4_valid_q && !s5_valid_q) begin
          state_d = gde_pkg::ST_SPAWN;
        end
      end
      gde_pkg::ST_SPAWN: begin
        state_d = ((cd_q == '0) && free_found_q) ? gde_pkg::ST_SP_MUL : gde_pkg::ST_FIN;
      end
      gde_pkg::ST_SP_MUL:  state_d = gde_pkg::ST_SP_RED1;
      gde_pkg::ST_SP_RED1: state_d = gde_pkg::ST_SP_RED2;
      gde_pkg::ST_SP_RED2: state_d = gde_pkg::ST_SP_SZDIV;
      gde_pkg::ST_SP_SZDIV: begin
        div_den = DW'(sp_siz_q);
        if (div_ok_q) begin
          div_take = 1'b1;
          state_d  = gde_pkg::ST_SP_DUDIV;
        end else if (!div_busy_q) begin
          div_start = 1'b1;
        end
      end
      gde_pkg::ST_SP_DUDIV: begin
        div_den = (sp_du_q == '0) ? DW'(1) : DW'(sp_du_q);
        if (div_ok_q) begin
          div_take = 1'b1;
          state_d  = gde_pkg::ST_SP_WRITE;
        end else if (!div_busy_q) begin
          div_start = 1'b1;
        end
      end
      gde_pkg::ST_SP_WRITE: begin
        gr_we    = 1'b1;
        gr_waddr = free_idx_q;
        gr_wdata.position   = {sp_st_q[16:0], {gde_pkg::FRAC_W{1'b0}}};
        gr_wdata.loop_start = sp_st_q[16:0];
        gr_wdata.loop_end   = (en_sum > 18'(len_c)) ? len_c : en_sum[16:0];
        gr_wdata.remaining  = sp_du_q;
        gr_wdata.rate       = gde_pkg::RATE_W'(sp_prt_q[25:15]);
        gr_wdata.phase      = '0;
        gr_wdata.phase_step = sp_pstep_q;
        gr_wdata.life_phase = '0;
        gr_wdata.life_step  = div_step;
        state_d = gde_pkg::ST_FIN;
      end
      gde_pkg::ST_FIN: begin
        st_we    = !freeze_q;
        st_waddr = AW'(wi_q);
        st_wdata = {in_q.right_in, in_q.left_in};
        state_d  = gde_pkg::ST_GAIN;
      end
      gde_pkg::ST_GAIN: state_d = gde_pkg::ST_OUT;
      gde_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = gde_pkg::ST_IDLE;
        end
      end
      default: state_d = gde_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gde_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- shared divider
  logic [DW:0]   dv_t;
  logic          dv_ge;

  always_comb begin
    dv_t  = {div_rem_q, div_quo_q[DW-1]};
    dv_ge = dv_t >= {1'b0, div_den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_ok_q   <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      if (div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= DCW'(DW);
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
        if (div_cnt_q == DCW'(1)) begin
          div_busy_q <= 1'b0;
          div_ok_q   <= 1'b1;
        end
      end
      if (div_take) begin
        div_ok_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_quo_q <= div_num;
      div_rem_q <= '0;
      div_den_q <= div_den;
    end else if (div_busy_q) begin
      div_rem_q <= dv_ge ? DW'(dv_t - {1'b0, div_den_q}) : dv_t[DW-1:0];
      div_quo_q <= {div_quo_q[DW-2:0], dv_ge};
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      wi_q         <= '0;
      cd_q         <= '0;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      active_q     <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      s4_valid_q   <= 1'b0;
      s5_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == gde_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end

      if (in_i.valid && in_i.ready) begin
        idx_q        <= '0;
        free_found_q <= 1'b0;
      end

      if ((state_q == gde_pkg::ST_WRAP) && div_take) begin
        wi_q <= div_rem_q[LW-1:0];
      end

      // stage 0: walk the slots, note the first free one
      if (issue) begin
        idx_q <= idx_q + GIW'(1);
        if (!active_q[idx_q[GI-1:0]] && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= idx_q[GI-1:0];
        end
      end
      if (!stall) begin
        s1_valid_q <= issue_act;
      end
      if (s1_go && s1_drop) begin
        active_q[s1_idx_q] <= 1'b0;
      end
      s2_valid_q <= s1_go;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;

      if (state_q == gde_pkg::ST_SPAWN) begin
        if (cd_q == '0) begin
          cd_q <= (spacing_q == '0) ? '0 : spacing_q - 13'd1;
        end else begin
          cd_q <= cd_q - 13'd1;
        end
      end
      if (state_q == gde_pkg::ST_SP_WRITE) begin
        active_q[free_idx_q] <= 1'b1;
      end

      if (state_q == gde_pkg::ST_FIN) begin
        wi_q <= ((wi_q + LW'(1)) >= len_c) ? '0 : wi_q + LW'(1);
      end

      if ((state_q == gde_pkg::ST_OUT) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q    <= in_i.data;
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (s5_valid_q) begin
      acc_l_q <= acc_l_q + {{(ACC_W - 34){s5_pl_q[33]}}, s5_pl_q};
      acc_r_q <= acc_r_q + {{(ACC_W - 34){s5_pr_q[33]}}, s5_pr_q};
    end

    if (issue_act) begin
      s1_idx_q <= idx_q[GI-1:0];
    end
    s2_ph_q  <= s1_rec.phase;
    s2_lph_q <= s1_rec.life_phase;
    s3_e1_q  <= envelope(s2_ph_q);
    s3_e2_q  <= envelope(s2_lph_q);
    s3_smp_q <= st_rdata_q;
    s4_w_q   <= 17'((34'(s3_e1_q) * 34'(s3_e2_q)) >> 16);
    s4_smp_q <= s3_smp_q;
    s5_pl_q  <= $signed(s4_smp_q[15:0]) * $signed({1'b0, s4_w_q});
    s5_pr_q  <= $signed(s4_smp_q[31:16]) * $signed({1'b0, s4_w_q});

    if (state_q == gde_pkg::ST_SP_MUL) begin
      sp_pst_q <= 33'(f_start) * 33'(len_c);
      sp_psz_q <= 29'(size_q) * 29'(f_size);
      sp_pdu_q <= 33'(duration_q) * 33'(f_dur);
      sp_prt_q <= 26'(speed_q) * 26'(f_speed);
    end
    if (state_q == gde_pkg::ST_SP_RED1) begin
      sp_st_q  <= (red1_sum >= 19'(len_c)) ? red1_sum - 19'(len_c) : red1_sum;
      sp_siz_q <= (siz_raw == '0) ? gde_pkg::SIZE_W'(1) : siz_raw;
      sp_du_q  <= sp_pdu_q[32:15];
    end
    if (state_q == gde_pkg::ST_SP_RED2) begin
      sp_st_q <= (sp_st_q >= 19'(len_c)) ? sp_st_q - 19'(len_c) : sp_st_q;
    end
    if ((state_q == gde_pkg::ST_SP_SZDIV) && div_ok_q) begin
      sp_pstep_q <= div_step;
    end

    if (state_q == gde_pkg::ST_GAIN) begin
      g_lo_l_q <= 36'(acc_l_q[19:0]) * 36'(gain_q);
      g_lo_r_q <= 36'(acc_r_q[19:0]) * 36'(gain_q);
      g_hi_l_q <= $signed(acc_l_q[ACC_W-1:20]) * $signed({1'b0, gain_q});
      g_hi_r_q <= $signed(acc_r_q[ACC_W-1:20]) * $signed({1'b0, gain_q});
    end
    if ((state_q == gde_pkg::ST_OUT) && (!out_valid_q || out_o.ready)) begin
      out_q <= res;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_stall_needs_grain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> s1_valid_q)
    else $error("stall without a grain in stage 1");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy_q && !div_ok_q)
    else $error("divider restarted while in use");

  a_div_done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_ok_q) |-> $past(div_busy_q))
    else $error("divider result without a run");

  a_no_beat_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gde_pkg::ST_CLEAR) |-> !in_i.ready && !out_valid_q)
    else $error("beat during store clearing");

  a_pipe_empty_on_spawn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gde_pkg::ST_SP_WRITE) |-> !s1_valid_q && !gr_re)
    else $error("spawn write overlaps the record walk");

endmodule

@@ test/testbench.sv @@
// Self-checking bench for the granular delay engine: random and directed beats
// against a cycle-free predictor of the grain pool. Needs gde_pkg, gde_stream_if.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned POOL       = 64;
  localparam int unsigned STORE      = 65536;
  localparam longint      CYCLE_CAP  = 20000000;
  localparam int unsigned LONG_HOLD  = 800;
  localparam int unsigned SETTLE     = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [gde_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [gde_pkg::CFG_W-1:0] cfg_data_i = '0;

  gde_stream_if #(.T(gde_pkg::in_item_t))  in_ch ();
  gde_stream_if #(.T(gde_pkg::out_item_t)) out_ch ();

  granular_delay_engine uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted engine state
  bit [31:0]   store_mem [STORE];
  bit          g_on [POOL];
  int unsigned g_pos [POOL], g_lstart [POOL], g_lend [POOL], g_left [POOL];
  int unsigned g_rate [POOL], g_ph [POOL], g_phstep [POOL], g_lph [POOL], g_lstep [POOL];
  int unsigned wr_idx, spawn_cnt;
  int unsigned c_gain = 1024, c_grains = 10, c_len = 48000, c_freeze = 0;
  int unsigned c_spacing = 960, c_size = 1440, c_dur = 14400, c_speed = 256;

  gde_pkg::in_item_t  pending_items [$];
  gde_pkg::out_item_t expected_frames [$];
  int unsigned mismatches = 0;
  int unsigned hold_req = 0, hold_seen = 0;

  function automatic longint unsigned env_weight(longint unsigned p);
    return (p * (gde_pkg::PH_ONE - p)) >> 16;
  endfunction

  function automatic longint unsigned jit_scale(logic signed [15:0] j);
    return longint'(32768 + int'(j));
  endfunction

  function automatic int unsigned step_for(longint unsigned n);
    longint unsigned s;
    s = 131072 / n;
    return (s > 65535) ? 65535 : 32'(s);
  endfunction

  function automatic logic signed [15:0] sat_q15(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic granular_predict(input gde_pkg::in_item_t it, output gde_pkg::out_item_t r);
    longint unsigned len, lenq, pos, st, siz, du, en, w;
    longint acc_l, acc_r;
    int cnt, free_slot;
    bit [31:0] word;
    len = c_len;
    if (len < 1) len = 1;
    if (len > STORE) len = STORE;
    lenq = len << 8;
    cnt = (c_grains > POOL) ? int'(POOL) : int'(c_grains);
    free_slot = -1;
    acc_l = 0;
    acc_r = 0;
    if (wr_idx >= len) wr_idx = 32'(wr_idx % len);
    for (int i = 0; i < cnt; i++) begin
      if (g_on[i]) begin
        pos = longint'(g_pos[i]) + g_rate[i];
        if (pos >= (longint'(g_lend[i]) << 8)) pos = longint'(g_lstart[i]) << 8;
        if (pos >= lenq) pos -= lenq;
        if (pos >= lenq) pos %= lenq;
        g_pos[i] = 32'(pos);
        g_ph[i] += g_phstep[i];
        if (g_ph[i] >= gde_pkg::PH_ONE) g_ph[i] -= gde_pkg::PH_ONE;
        g_lph[i] += g_lstep[i];
        if (g_lph[i] >= gde_pkg::PH_ONE) g_lph[i] -= gde_pkg::PH_ONE;
        // retire after this step's contribution
        if (g_left[i] <= 1) begin
          g_left[i] = 0;
          g_on[i] = 1'b0;
        end else begin
          g_left[i] -= 1;
        end
        w = (env_weight(g_ph[i]) * env_weight(g_lph[i])) >> 16;
        word = store_mem[(pos >> 8) % STORE];
        acc_l += longint'(signed'(word[15:0])) * longint'(w);
        acc_r += longint'(signed'(word[31:16])) * longint'(w);
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (spawn_cnt == 0) begin
      spawn_cnt = (c_spacing != 0) ? c_spacing : 1;
      if (free_slot >= 0) begin
        st = (wr_idx + ((jit_scale(it.start_jitter) * len) >> 15)) % len;
        siz = (longint'(c_size) * jit_scale(it.size_jitter)) >> 15;
        du = (longint'(c_dur) * jit_scale(it.duration_jitter)) >> 15;
        if (siz < 1) siz = 1;
        en = st + siz;
        if (en > len) en = len;
        g_on[free_slot] = 1'b1;
        g_pos[free_slot] = 32'(st << 8);
        g_lstart[free_slot] = 32'(st);
        g_lend[free_slot] = 32'(en);
        g_left[free_slot] = 32'(du);
        g_rate[free_slot] = 32'((longint'(c_speed) * jit_scale(it.speed_jitter)) >> 15);
        g_ph[free_slot] = 0;
        g_phstep[free_slot] = step_for(siz);
        g_lph[free_slot] = 0;
        g_lstep[free_slot] = step_for((du != 0) ? du : 1);
      end
    end
    spawn_cnt -= 1;
    if (c_freeze == 0) store_mem[wr_idx % STORE] = {it.right_in, it.left_in};
    wr_idx += 1;
    if (wr_idx >= len) wr_idx -= 32'(len);
    r.left_out = sat_q15((acc_l * longint'(c_gain)) >>> 26);
    r.right_out = sat_q15((acc_r * longint'(c_gain)) >>> 26);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40) $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // Driver: offer queued beats, predicting each one as it is taken
  int unsigned gap_left = 0, sent_count = 0;
  gde_pkg::out_item_t predicted;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        granular_predict(in_ch.data, predicted);
        expected_frames.push_back(predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_ch.data <= pending_items.pop_front();
          in_ch.valid <= 1'b1;
          sent_count++;
          gap_left = ((sent_count / 50) % 3 == 2) ? 0 : $urandom_range(0, 11);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat and throttle ready
  int unsigned stall_left = 0, recv_count = 0;
  gde_pkg::out_item_t want;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      stall_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        recv_count++;
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.data.left_out, 0);
        end else begin
          want = expected_frames.pop_front();
          if (out_ch.data.left_out !== want.left_out)
            report_mismatch("left_out", out_ch.data.left_out, want.left_out);
          if (out_ch.data.right_out !== want.right_out)
            report_mismatch("right_out", out_ch.data.right_out, want.right_out);
        end
        stall_left = ((recv_count / 70) % 3 == 1) ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(gde_pkg::cfg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[gde_pkg::CFG_W-1:0];
    case (idx)
      gde_pkg::REG_MASTER_GAIN:    c_gain = val & 32'hffff;
      gde_pkg::REG_ACTIVE_GRAINS:  c_grains = val & 32'h7f;
      gde_pkg::REG_BUFFER_LENGTH:  c_len = val & 32'h1ffff;
      gde_pkg::REG_FREEZE:         c_freeze = val & 32'h1;
      gde_pkg::REG_GRAIN_SPACING:  c_spacing = val & 32'h1fff;
      gde_pkg::REG_GRAIN_SIZE:     c_size = val & 32'h1fff;
      gde_pkg::REG_GRAIN_DURATION: c_dur = val & 32'h1ffff;
      gde_pkg::REG_GRAIN_SPEED:    c_speed = val & 32'h3ff;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(int unsigned g, int unsigned n, int unsigned l, int unsigned f,
                               int unsigned sp, int unsigned sz, int unsigned du,
                               int unsigned spd);
    write_reg(gde_pkg::REG_MASTER_GAIN, g);
    write_reg(gde_pkg::REG_ACTIVE_GRAINS, n);
    write_reg(gde_pkg::REG_BUFFER_LENGTH, l);
    write_reg(gde_pkg::REG_FREEZE, f);
    write_reg(gde_pkg::REG_GRAIN_SPACING, sp);
    write_reg(gde_pkg::REG_GRAIN_SIZE, sz);
    write_reg(gde_pkg::REG_GRAIN_DURATION, du);
    write_reg(gde_pkg::REG_GRAIN_SPEED, spd);
  endtask

  // Wait for the block to drain, then let it settle before a register write
  task automatic drain();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || expected_frames.size() != 0 || in_ch.valid);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_jitter();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_random(int unsigned n);
    gde_pkg::in_item_t it;
    repeat (n) begin
      it.left_in = 16'($urandom());
      it.right_in = 16'($urandom());
      it.start_jitter = pick_jitter();
      it.speed_jitter = pick_jitter();
      it.size_jitter = pick_jitter();
      it.duration_jitter = pick_jitter();
      pending_items.push_back(it);
    end
  endtask

  task automatic queue_directed();
    logic signed [15:0] edges [4];
    gde_pkg::in_item_t it;
    edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    for (int i = 0; i < 20; i++) begin
      it.left_in = edges[i % 4];
      it.right_in = edges[(i + 1) % 4];
      it.start_jitter = edges[(i / 4) % 4];
      it.speed_jitter = edges[(i + 2) % 4];
      it.size_jitter = edges[(i / 2) % 4];
      it.duration_jitter = edges[(i + 3) % 4];
      pending_items.push_back(it);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, then extremes on a short store with fast spawns
    queue_random(8);
    drain();
    apply_setting(1024, 8, 64, 0, 1, 4, 6, 256);
    queue_directed();
    drain();
    // zero size, zero lifetime, zero spacing, empty pool, store length clamped low
    apply_setting(65535, 0, 0, 0, 0, 0, 0, 0);
    queue_random(40);
    drain();
    apply_setting(65535, 4, 1, 0, 0, 0, 0, 1023);
    queue_random(60);
    drain();
    // full pool with no free slot, gain saturating; receiver holds off meanwhile
    apply_setting(65535, 64, 1000, 0, 1, 20, 300, 1023);
    hold_req <= hold_req + 1;
    queue_random(200);
    drain();
    // grain count and store length above range, frozen store, rare spawns
    apply_setting(3000, 127, 131071, 1, 4800, 4800, 96000, 512);
    queue_random(80);
    drain();
    // long store, then shrink it under live grains
    apply_setting(2048, 16, 4000, 0, 2, 300, 400, 700);
    queue_random(150);
    drain();
    write_reg(gde_pkg::REG_BUFFER_LENGTH, 100);
    queue_random(150);
    drain();
    write_reg(gde_pkg::REG_BUFFER_LENGTH, 65536);
    write_reg(gde_pkg::REG_FREEZE, 1);
    queue_random(60);
    drain();
    for (int p = 0; p < 10; p++) begin
      apply_setting($urandom_range(0, 65535),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(1, 3000),
                    $urandom_range(0, 1),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                                : $urandom_range(0, 12),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                                : $urandom_range(0, 200),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 600),
                    $urandom_range(0, 1023));
      queue_random(120);
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
